[design/rgb_channel_histogram_unit_assert.svh]
// Assertion macros shared by the histogram unit's checker.
`ifndef RGB_CHANNEL_HISTOGRAM_UNIT_ASSERT_SVH
`define RGB_CHANNEL_HISTOGRAM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, or later through ##.
`define RCH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram unit assertion failed");

`endif

[design/rch_pkg.sv]
// Shared types and constants of the RGB channel histogram unit.
package rch_pkg;

  localparam int NUM_LANES      = 3;
  localparam int BIN_COUNT      = 256;
  localparam int BIN_BITS       = 8;
  localparam int OUT_BITS       = 24;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 120;
  localparam int IN_TUSER_BITS  = 2;

  // Operation carried in tuser.
  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Channel selector of a read.
  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } channel_t;

  // Control shared by all lanes.
  typedef struct packed {
    logic fetch;   // read the addressed bin into the lane's read register
    logic commit;  // write back the incremented bin and update the peak
    logic clear;   // drop every bin and the peak to zero
  } lane_ctl_t;

endpackage

[design/rgb_channel_histogram_unit.sv]
// Top level of the RGB channel histogram unit.
//
// Channel | Direction | Handshake            | Contents
// in_     | slave     | in_tvalid/in_tready  | tuser: action; tdata: pixel, channel, bin
// out_    | master    | out_tvalid/out_tready| tdata: bin count, three peaks, pixel total
//
// Accumulate and read are taken in S_IDLE, which reads the bin memories, and finish in
// S_UPDATE, which writes back or loads the result register. Clear and an unused action finish in S_IDLE.
// Reset clears the bin valid bits, peaks and pixel counter at once; no sweep.
// A read waits in S_UPDATE while the result register is full and stalled.
module rgb_channel_histogram_unit #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata from bit 0: blue[7:0], green[15:8], red[23:16], channel[25:24],
  // bin_index[33:26], zero fill[39:34]
  input  logic [rch_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  // tuser: action[1:0]
  input  logic [rch_pkg::IN_TUSER_BITS-1:0]   in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata from bit 0: bin_count[23:0], blue_peak[47:24], green_peak[71:48],
  // red_peak[95:72], pixel_total[119:96]
  output logic [rch_pkg::OUT_TDATA_BITS-1:0]  out_tdata
);
  import rch_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  state_t                state_r, state_nxt;
  logic                  in_acc;
  logic                  is_accum, is_read, is_clear;
  logic                  is_read_r, is_read_nxt;
  logic [1:0]            channel_r;
  logic [1:0]            in_channel;
  logic [BIN_BITS-1:0]   in_bin;
  logic [BIN_BITS-1:0]   lane_addr [NUM_LANES];
  logic [COUNT_BITS-1:0] lane_count [NUM_LANES];
  logic [COUNT_BITS-1:0] lane_peak [NUM_LANES];
  logic [COUNT_BITS-1:0] pixel_r, pixel_nxt;
  lane_ctl_t             ctl;
  logic                  load;
  logic                  can_load;

  assign in_channel = in_tdata[25:24];
  assign in_bin     = in_tdata[33:26];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  // Decode the action of the incoming beat.
  always_comb begin
    is_accum = 1'b0;
    is_read  = 1'b0;
    is_clear = 1'b0;
    case (action_t'(in_tuser))
      ACT_ACCUM: is_accum = 1'b1;
      ACT_READ:  is_read  = 1'b1;
      ACT_CLEAR: is_clear = 1'b1;
      default:   ;
    endcase
  end

  // Lane control and hand-off to the merge stage.
  assign ctl.fetch  = in_acc && (is_accum || is_read);
  assign ctl.commit = (state_r == S_UPDATE) && !is_read_r;
  assign ctl.clear  = in_acc && is_clear;
  assign load       = (state_r == S_UPDATE) && is_read_r && can_load;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    is_read_nxt = is_read_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.fetch) begin
          state_nxt   = S_UPDATE;
          is_read_nxt = is_read;
        end
      end
      S_UPDATE: begin
        if (!is_read_r || can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Saturating pixel counter.
  always_comb begin
    pixel_nxt = pixel_r;
    if (ctl.clear) begin
      pixel_nxt = '0;
    end else if (ctl.commit && pixel_r != CountMax) begin
      pixel_nxt = pixel_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      is_read_r <= 1'b0;
      pixel_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      is_read_r <= is_read_nxt;
      pixel_r   <= pixel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      channel_r <= in_channel;
    end
  end

  // One lane per color byte; a read addresses all lanes at the same bin.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    assign lane_addr[i] = is_read ? in_bin : in_tdata[BIN_BITS*i +: BIN_BITS];

    rch_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .addr  (lane_addr[i]),
      .count (lane_count[i]),
      .peak  (lane_peak[i])
    );
  end

  rch_merge #(
    .COUNT_BITS(COUNT_BITS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .channel     (channel_r),
    .lane_count  (lane_count),
    .lane_peak   (lane_peak),
    .pixel_total (pixel_r),
    .can_load    (can_load),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

[design/rch_lane.sv]
// One channel lane: 256-bin count memory, valid bits, saturating update and peak.
module rch_lane #(
  parameter int COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rch_pkg::lane_ctl_t              ctl,
  input  logic [rch_pkg::BIN_BITS-1:0]    addr,
  output logic [COUNT_BITS-1:0]           count,
  output logic [COUNT_BITS-1:0]           peak
);
  import rch_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] mem [BIN_COUNT];
  logic [BIN_COUNT-1:0]  valid_r, valid_nxt;
  logic [BIN_BITS-1:0]   addr_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_valid_r;
  logic [COUNT_BITS-1:0] peak_r, peak_nxt;
  logic [COUNT_BITS-1:0] inc;

  // Memory port: registered read on fetch, write back on commit.
  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      rd_data_r  <= mem[addr];
      rd_valid_r <= valid_r[addr];
      addr_r     <= addr;
    end
    if (ctl.commit) begin
      mem[addr_r] <= inc;
    end
  end

  // A bin never written since reset or clear reads as zero.
  assign count = rd_valid_r ? rd_data_r : '0;
  assign inc   = (count == CountMax) ? CountMax : count + 1'b1;

  always_comb begin
    valid_nxt = valid_r;
    peak_nxt  = peak_r;
    if (ctl.clear) begin
      valid_nxt = '0;
      peak_nxt  = '0;
    end else if (ctl.commit) begin
      valid_nxt[addr_r] = 1'b1;
      if (inc > peak_r) begin
        peak_nxt = inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      peak_r  <= peak_nxt;
    end
  end

  assign peak = peak_r;

endmodule

[design/rch_merge.sv]
// Merge stage: picks the read channel's count and holds the result beat.
module rch_merge #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [1:0]                           channel,
  input  logic [COUNT_BITS-1:0]                lane_count [rch_pkg::NUM_LANES],
  input  logic [COUNT_BITS-1:0]                lane_peak [rch_pkg::NUM_LANES],
  input  logic [COUNT_BITS-1:0]                pixel_total,
  output logic                                 can_load,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rch_pkg::OUT_TDATA_BITS-1:0]   out_tdata
);
  import rch_pkg::*;

  logic                      valid_r, valid_nxt;
  logic [OUT_TDATA_BITS-1:0] data_r;
  logic [COUNT_BITS-1:0]     sel_count;

  // Channel select; an unused channel code reads zero.
  always_comb begin
    case (channel)
      CH_BLUE:  sel_count = lane_count[0];
      CH_GREEN: sel_count = lane_count[1];
      CH_RED:   sel_count = lane_count[2];
      default:  sel_count = '0;
    endcase
  end

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result beat, bin count in the lowest bits.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {OUT_BITS'(pixel_total), OUT_BITS'(lane_peak[2]), OUT_BITS'(lane_peak[1]),
                 OUT_BITS'(lane_peak[0]), OUT_BITS'(sel_count)};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

[design/rch_checker.sv]
// Port-level checker of the histogram unit and its bind.
`include "rgb_channel_histogram_unit_assert.svh"

module rch_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [rch_pkg::IN_TUSER_BITS-1:0]   in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rch_pkg::OUT_TDATA_BITS-1:0]  out_tdata
);
  import rch_pkg::*;

  logic in_acc;
  logic acc_read;
  logic acc_update;

  assign in_acc     = in_tvalid && in_tready;
  assign acc_read   = in_acc && (in_tuser == ACT_READ);
  assign acc_update = in_acc && (in_tuser == ACT_READ || in_tuser == ACT_ACCUM);

  // An accumulate or read beat occupies the unit for its update cycle.
  `RCH_ASSERT_NEXT(a_busy_after_update, acc_update, !in_tready)
  // A read with an empty result register delivers its beat once the update state has loaded the result register.
  `RCH_ASSERT_NOW(a_read_gives_result, acc_read && !out_tvalid, ##2 out_tvalid)
  // Beats other than reads never produce a result.
  `RCH_ASSERT_NOW(a_no_spurious_result, in_acc && !acc_read && !out_tvalid, ##2 !out_tvalid)
  // A stalled result beat holds.
  `RCH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind rgb_channel_histogram_unit rch_checker u_rch_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the RGB channel histogram unit.
`timescale 1ns / 100ps

module testbench;
  import rch_pkg::*;

  // A narrow count width for the unit under test.
  localparam int          COUNT_BITS  = 16;
  localparam logic [31:0] COUNT_MAX   = (32'd1 << COUNT_BITS) - 32'd1;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [1:0]  CH_UNUSED   = 2'd3;
  localparam int          HOLD_CYCLES = 300;
  localparam int          RANDOM_PER_PHASE = 340;
  localparam int          REPEAT_BURST = 40;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] channel;
    logic [7:0] bin_index;
  } pixel_cmd_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] bin_count;
    logic [OUT_BITS-1:0] blue_peak;
    logic [OUT_BITS-1:0] green_peak;
    logic [OUT_BITS-1:0] red_peak;
    logic [OUT_BITS-1:0] pixel_total;
  } bin_report_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;
  logic [IN_TUSER_BITS-1:0]  in_tuser = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;

  // Stimulus and expectation stores.
  pixel_cmd_t  cmd_fifo[$];
  pixel_cmd_t  cmd_on_bus;
  bin_report_t expected_reports[$];

  // Predicted histogram state.
  logic [31:0] hist_bins [3][BIN_COUNT];
  logic [31:0] peak_counts [3];
  logic [31:0] pixel_count;

  // Traffic shaping.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_armed = 1'b0;
  logic rx_hold = 1'b0;

  // Run statistics.
  int   failures = 0;
  int   n_accum = 0;
  int   n_read = 0;
  int   n_clear = 0;
  int   n_unused = 0;
  int   n_checked = 0;
  logic saw_saturation = 1'b0;

  rgb_channel_histogram_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 32'd1;
  endfunction

  // Apply one accepted beat to the predicted state; reads queue a report.
  function automatic void update_histogram(input pixel_cmd_t cmd);
    bin_report_t rpt;
    logic [7:0]  pix [3];
    pix = '{cmd.blue, cmd.green, cmd.red};
    case (cmd.action)
      ACT_ACCUM: begin
        for (int ch = 0; ch < 3; ch++) begin
          hist_bins[ch][pix[ch]] = sat_inc(hist_bins[ch][pix[ch]]);
          if (hist_bins[ch][pix[ch]] > peak_counts[ch])
            peak_counts[ch] = hist_bins[ch][pix[ch]];
          if (hist_bins[ch][pix[ch]] == COUNT_MAX)
            saw_saturation = 1'b1;
        end
        pixel_count = sat_inc(pixel_count);
        n_accum++;
      end
      ACT_READ: begin
        rpt.bin_count = '0;
        if (cmd.channel != CH_UNUSED)
          rpt.bin_count = OUT_BITS'(hist_bins[cmd.channel][cmd.bin_index]);
        rpt.blue_peak   = OUT_BITS'(peak_counts[CH_BLUE]);
        rpt.green_peak  = OUT_BITS'(peak_counts[CH_GREEN]);
        rpt.red_peak    = OUT_BITS'(peak_counts[CH_RED]);
        rpt.pixel_total = OUT_BITS'(pixel_count);
        expected_reports.push_back(rpt);
        n_read++;
      end
      ACT_CLEAR: begin
        foreach (hist_bins[ch, b]) hist_bins[ch][b] = '0;
        foreach (peak_counts[ch]) peak_counts[ch] = '0;
        pixel_count = '0;
        n_clear++;
      end
      default: begin
        n_unused++;
      end
    endcase
  endfunction

  // Input driver: offers the next pending command, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        update_histogram(cmd_on_bus);
      if (!in_tvalid || in_tready) begin
        if (cmd_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = cmd_fifo.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cmd_on_bus.action;
          in_tdata  <= {6'b0, cmd_on_bus.bin_index, cmd_on_bus.channel,
                        cmd_on_bus.red, cmd_on_bus.green, cmd_on_bus.blue};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [OUT_BITS-1:0] exp_v,
                             input logic [OUT_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // Result monitor: compares each report beat with the oldest prediction.
  always @(posedge clk) begin
    bin_report_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("Unexpected report beat: %h", out_tdata);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          check_field("bin_count",   want.bin_count,   out_tdata[23:0]);
          check_field("blue_peak",   want.blue_peak,   out_tdata[47:24]);
          check_field("green_peak",  want.green_peak,  out_tdata[71:48]);
          check_field("red_peak",    want.red_peak,    out_tdata[95:72]);
          check_field("pixel_total", want.pixel_total, out_tdata[119:96]);
          n_checked++;
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send(input logic [1:0] action, input logic [7:0] b, input logic [7:0] g,
                      input logic [7:0] r, input logic [1:0] ch, input logic [7:0] bin);
    pixel_cmd_t cmd;
    cmd = '{action, b, g, r, ch, bin};
    cmd_fifo.push_back(cmd);
  endtask

  // Bytes crowd into a few bins at both ends so counts and peaks grow.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(3));
      1:       return 8'hFF - 8'($urandom_range(3));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    int          roll;
    logic [1:0]  act;
    logic [1:0]  ch;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(999);
      if (roll < 600)      act = ACT_ACCUM;
      else if (roll < 960) act = ACT_READ;
      else if (roll < 980) act = ACT_CLEAR;
      else                 act = ACT_UNUSED;
      ch = ($urandom_range(99) < 5) ? CH_UNUSED : 2'($urandom_range(2));
      send(act, pick_byte(), pick_byte(), pick_byte(), ch, pick_byte());
    end
  endtask

  task automatic wait_drained();
    while (cmd_fifo.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random(count);
    wait_drained();
  endtask

  // Stimulus sequence.
  initial begin
    int spins;
    foreach (hist_bins[ch, b]) hist_bins[ch][b] = '0;
    foreach (peak_counts[ch]) peak_counts[ch] = '0;
    pixel_count = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes of every field, every action, unused action and channel.
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_BLUE,   8'h00);
    send(ACT_ACCUM,  8'h00, 8'h00, 8'h00, CH_BLUE,   8'h00);
    send(ACT_ACCUM,  8'hFF, 8'hFF, 8'hFF, CH_UNUSED, 8'hFF);
    send(ACT_ACCUM,  8'h00, 8'h80, 8'hFF, CH_RED,    8'hFF);
    send(ACT_READ,   8'hFF, 8'hFF, 8'hFF, CH_BLUE,   8'h00);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_GREEN,  8'hFF);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_RED,    8'hFF);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_GREEN,  8'h80);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_UNUSED, 8'h00);
    send(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, CH_UNUSED, 8'hFF);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_RED,    8'hFF);
    send(ACT_CLEAR,  8'hFF, 8'hFF, 8'hFF, CH_UNUSED, 8'hFF);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_BLUE,   8'h00);
    // Back-to-back hits on one bin, then an immediate read of it.
    send(ACT_ACCUM,  8'h3C, 8'hC3, 8'h5A, CH_BLUE,   8'h00);
    send(ACT_ACCUM,  8'h3C, 8'hC3, 8'h5A, CH_BLUE,   8'h00);
    send(ACT_ACCUM,  8'h3C, 8'hC3, 8'h5A, CH_BLUE,   8'h00);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_BLUE,   8'h3C);
    send(ACT_ACCUM,  8'h3C, 8'h00, 8'h00, CH_GREEN,  8'hC3);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_GREEN,  8'hC3);
    send(ACT_READ,   8'h00, 8'h00, 8'h00, CH_RED,    8'h5A);
    wait_drained();

    // Repeated pixel: one bin per channel pulls its peak well ahead.
    send(ACT_CLEAR, 8'h00, 8'h00, 8'h00, CH_BLUE, 8'h00);
    for (int i = 0; i < REPEAT_BURST; i++)
      send(ACT_ACCUM, 8'hA5, 8'h5A, 8'hA5, CH_BLUE, 8'h00);
    send(ACT_READ,  8'h00, 8'h00, 8'h00, CH_BLUE,   8'hA5);
    send(ACT_READ,  8'h00, 8'h00, 8'h00, CH_GREEN,  8'h5A);
    send(ACT_READ,  8'h00, 8'h00, 8'h00, CH_RED,    8'hA5);
    send(ACT_READ,  8'h00, 8'h00, 8'h00, CH_UNUSED, 8'hA5);
    send(ACT_CLEAR, 8'h00, 8'h00, 8'h00, CH_BLUE,   8'h00);
    send(ACT_READ,  8'h00, 8'h00, 8'h00, CH_RED,    8'hA5);
    wait_drained();

    // Random traffic under each idling pattern.
    run_phase(0,  0,  RANDOM_PER_PHASE);
    run_phase(71, 0,  RANDOM_PER_PHASE);
    run_phase(0,  71, RANDOM_PER_PHASE);
    run_phase(15, 15, RANDOM_PER_PHASE);

    // Backpressure: sender keeps offering while the receiver holds off.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b1;
    @(negedge clk);
    send_random(60);
    wait_drained();

    // Let any trailing accumulate settle.
    spins = 0;
    while (spins < 20 && (expected_reports.size() != 0 || in_tvalid)) begin
      @(negedge clk);
      spins++;
    end
    repeat (10) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d report beats never arrived", expected_reports.size());
      failures++;
    end

    $display("Covered %0d accumulates, %0d reads, %0d clears, %0d unused actions.",
             n_accum, n_read, n_clear, n_unused);
    $display("Checked %0d report beats; bin saturation reached: %0b.",
             n_checked, saw_saturation);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout: run did not complete.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/rch_pkg.sv
design/rch_lane.sv
design/rch_merge.sv
design/rgb_channel_histogram_unit.sv
design/rch_checker.sv
tb/testbench.sv
